// ===== sv/dpm_pkg.sv =====
// decaying peak meter package: sequencer states, register indexes, class codes,
// log2 interpolation table and fixed constants; no dependencies
package dpm_pkg;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_DECAY  = 9'b000000010,
    ST_PICK   = 9'b000000100,
    ST_NORM   = 9'b000001000,
    ST_INTERP = 9'b000010000,
    ST_ACCUM  = 9'b000100000,
    ST_SCALE  = 9'b001000000,
    ST_ROUND  = 9'b010000000,
    ST_EMIT   = 9'b100000000
  } state_t;

  typedef struct packed {
    logic load;
    logic run;
  } norm_ctl_t;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_LEVEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WARN_LEVEL = 2'd2;

  localparam logic [1:0] CLASS_SAFE = 2'd0;
  localparam logic [1:0] CLASS_WARN = 2'd1;
  localparam logic [1:0] CLASS_PEAK = 2'd2;

  localparam logic [15:0]       DECAY_GAIN_RST = 16'd62259;
  localparam logic signed [7:0] PEAK_LEVEL_RST = -8'sd10;
  localparam logic signed [7:0] WARN_LEVEL_RST = -8'sd20;

  // 20*log10(2) in q16
  localparam int               MB_W          = 19;
  localparam logic [MB_W-1:0]  DB_PER_LOG2   = 19'd394566;
  localparam int               NEG_W         = 21;
  localparam logic [15:0]      DB_FLOOR_Q8   = 16'd30720;
  localparam logic signed [16:0] BAR_OFFSET_Q8 = 17'sd15360;

  // log2(1 + k/16) in q1.16
  function automatic logic [16:0] log2_lut(input logic [4:0] k);
    logic [16:0] r;
    case (k)
      5'd0:    r = 17'd0;
      5'd1:    r = 17'd5732;
      5'd2:    r = 17'd11136;
      5'd3:    r = 17'd16248;
      5'd4:    r = 17'd21098;
      5'd5:    r = 17'd25711;
      5'd6:    r = 17'd30110;
      5'd7:    r = 17'd34312;
      5'd8:    r = 17'd38336;
      5'd9:    r = 17'd42196;
      5'd10:   r = 17'd45904;
      5'd11:   r = 17'd49472;
      5'd12:   r = 17'd52911;
      5'd13:   r = 17'd56229;
      5'd14:   r = 17'd59434;
      5'd15:   r = 17'd62534;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/dpm_mul.sv =====
// decaying peak meter shared multiplier, product registered
// no dependencies
module dpm_mul #(
  parameter int A_W = 23,
  parameter int B_W = 19
) (
  input  logic               clk,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic [A_W+B_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
  end

endmodule

// ===== sv/dpm_norm.sv =====
// normaliser: while run is set, shifts left one bit a cycle until the top bit is set
// depends on dpm_pkg
module dpm_norm #(
  parameter int W = 23
) (
  input  logic                  clk,
  input  dpm_pkg::norm_ctl_t    ctl,
  input  logic [W-1:0]          din,
  output logic [W-1:0]          norm,
  output logic [$clog2(W)-1:0]  cnt
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      norm <= din;
      cnt  <= '0;
    end else if (ctl.run && !norm[W-1]) begin
      norm <= {norm[W-2:0], 1'b0};
      cnt  <= cnt + 1'b1;
    end
  end

endmodule

// ===== sv/decaying_peak_meter.sv =====
// decaying peak meter top level: sequencer, state and config registers, output register
// depends on dpm_pkg, dpm_mul, dpm_norm
// a sample without buffer end is taken in idle; ready stays high
// a buffer end runs decay, pick, norm (one normaliser shift per leading zero of
// the held peak), interp, accum, scale, round, emit; a zero peak goes from pick to emit
// the shared multiplier does decay, interpolation and dB scaling; ready is low meanwhile
// synchronous reset clears peaks, config registers (to defaults) and the output valid
module decaying_peak_meter #(
  parameter int BAR_CELLS   = 60,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       sample,
  input  logic                                first_channel,
  input  logic                                buffer_end,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [$clog2(BAR_CELLS+1)-1:0]      bar_length,
  output logic [1:0]                          level_class,
  output logic signed [15:0]                  level_db,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dpm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [15:0]                         cfg_data
);

  localparam int MAG_BITS = SAMPLE_BITS - 1;
  localparam int A_W      = (MAG_BITS > dpm_pkg::NEG_W) ? MAG_BITS : dpm_pkg::NEG_W;
  localparam int P_W      = A_W + dpm_pkg::MB_W;
  localparam int M_W      = P_W - 24;
  localparam int CW       = $clog2(MAG_BITS);
  localparam int BAR_W    = $clog2(BAR_CELLS+1);
  localparam logic [7:0] BAR_MAX = 8'(BAR_CELLS - 1);

  dpm_pkg::state_t state;

  logic [15:0]       decay_gain;
  logic signed [7:0] peak_level_db;
  logic signed [7:0] warn_level_db;
  logic [MAG_BITS-1:0] buffer_max;
  logic [MAG_BITS-1:0] held_peak;
  logic [16:0]       base;
  logic [dpm_pkg::NEG_W-1:0] neg;
  logic signed [15:0] db;

  // sample fold
  logic [MAG_BITS-1:0] smag;
  logic [MAG_BITS-1:0] bm_fold;
  assign smag    = sample[MAG_BITS-1:0];
  assign bm_fold = (first_channel && !sample[SAMPLE_BITS-1] && (smag > buffer_max)) ?
                   smag : buffer_max;

  // shared multiplier
  logic [A_W-1:0]           mul_a;
  logic [dpm_pkg::MB_W-1:0] mul_b;
  logic [P_W-1:0]           prod;

  dpm_mul #(.A_W(A_W), .B_W(dpm_pkg::MB_W)) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // normaliser
  dpm_pkg::norm_ctl_t  norm_ctl;
  logic [MAG_BITS-1:0] norm_val;
  logic [CW-1:0]       norm_cnt;
  logic [MAG_BITS-1:0] decayed;
  logic [MAG_BITS-1:0] pk;

  assign decayed = prod[MAG_BITS+15:16];
  assign pk      = (buffer_max > decayed) ? buffer_max : decayed;

  dpm_norm #(.W(MAG_BITS)) u_norm (
    .clk  (clk),
    .ctl  (norm_ctl),
    .din  (pk),
    .norm (norm_val),
    .cnt  (norm_cnt)
  );

  // table interpolation
  logic [30:0] frac;
  logic [3:0]  idx;
  logic [17:0] rem;
  logic [16:0] lut_lo;
  logic [16:0] lut_hi;
  logic [12:0] diff;
  logic [16:0] interp;

  assign frac   = 31'(norm_val[MAG_BITS-2:0]) << (32 - MAG_BITS);
  assign idx    = frac[30:27];
  assign rem    = frac[26:9];
  assign lut_lo = dpm_pkg::log2_lut({1'b0, idx});
  assign lut_hi = dpm_pkg::log2_lut(5'(idx) + 5'd1);
  assign diff   = 13'(lut_hi - lut_lo);
  assign interp = base + 17'(prod[30:18]);

  // rounding to q8.8
  logic [P_W-1:0] rnd;
  logic [M_W-1:0] mag;
  logic [15:0]    mag_c;
  assign rnd   = prod + P_W'(1 << 23);
  assign mag   = rnd[P_W-1:24];
  assign mag_c = (mag > M_W'(dpm_pkg::DB_FLOOR_Q8)) ? dpm_pkg::DB_FLOOR_Q8 : 16'(mag);

  // bar and class
  logic signed [16:0] bar_v;
  logic [7:0]         adj;
  logic [7:0]         adj_c;
  logic [BAR_W-1:0]   bar_next;
  logic [1:0]         class_next;

  assign bar_v    = {db[15], db} + dpm_pkg::BAR_OFFSET_Q8;
  assign adj      = bar_v[16] ? 8'd0 : bar_v[15:8];
  assign adj_c    = (adj > BAR_MAX) ? BAR_MAX : adj;
  assign bar_next = BAR_W'({1'b0, adj_c} + 9'd1);

  always_comb begin
    if (db > $signed({peak_level_db, 8'h00})) begin
      class_next = dpm_pkg::CLASS_PEAK;
    end else if (db > $signed({warn_level_db, 8'h00})) begin
      class_next = dpm_pkg::CLASS_WARN;
    end else begin
      class_next = dpm_pkg::CLASS_SAFE;
    end
  end

  always_comb begin
    mul_a = A_W'(held_peak);
    mul_b = dpm_pkg::MB_W'(decay_gain);
    if (state == dpm_pkg::ST_INTERP) begin
      mul_a = A_W'(diff);
      mul_b = dpm_pkg::MB_W'(rem);
    end else if (state == dpm_pkg::ST_SCALE) begin
      mul_a = A_W'(neg);
      mul_b = dpm_pkg::DB_PER_LOG2;
    end
  end

  always_comb begin
    norm_ctl.load = (state == dpm_pkg::ST_PICK);
    norm_ctl.run  = (state == dpm_pkg::ST_NORM);
  end

  assign in_ready  = (state == dpm_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      decay_gain    <= dpm_pkg::DECAY_GAIN_RST;
      peak_level_db <= dpm_pkg::PEAK_LEVEL_RST;
      warn_level_db <= dpm_pkg::WARN_LEVEL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dpm_pkg::REG_DECAY_GAIN: decay_gain    <= cfg_data;
        dpm_pkg::REG_PEAK_LEVEL: peak_level_db <= cfg_data[7:0];
        dpm_pkg::REG_WARN_LEVEL: warn_level_db <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= dpm_pkg::ST_IDLE;
      out_valid  <= 1'b0;
      buffer_max <= '0;
      held_peak  <= '0;
    end else begin
      if (state == dpm_pkg::ST_EMIT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        dpm_pkg::ST_IDLE: begin
          if (in_valid) begin
            buffer_max <= bm_fold;
            if (buffer_end) begin
              state <= dpm_pkg::ST_DECAY;
            end
          end
        end
        dpm_pkg::ST_DECAY: begin
          state <= dpm_pkg::ST_PICK;
        end
        dpm_pkg::ST_PICK: begin
          held_peak  <= pk;
          buffer_max <= '0;
          if (pk == '0) begin
            db    <= -$signed(dpm_pkg::DB_FLOOR_Q8);
            state <= dpm_pkg::ST_EMIT;
          end else begin
            state <= dpm_pkg::ST_NORM;
          end
        end
        dpm_pkg::ST_NORM: begin
          if (norm_val[MAG_BITS-1]) begin
            state <= dpm_pkg::ST_INTERP;
          end
        end
        dpm_pkg::ST_INTERP: begin
          base  <= lut_lo;
          state <= dpm_pkg::ST_ACCUM;
        end
        dpm_pkg::ST_ACCUM: begin
          neg   <= {5'(norm_cnt) + 5'd1, 16'h0000} - dpm_pkg::NEG_W'(interp);
          state <= dpm_pkg::ST_SCALE;
        end
        dpm_pkg::ST_SCALE: begin
          state <= dpm_pkg::ST_ROUND;
        end
        dpm_pkg::ST_ROUND: begin
          db    <= -$signed(mag_c);
          state <= dpm_pkg::ST_EMIT;
        end
        dpm_pkg::ST_EMIT: begin
          if (!out_valid || out_ready) begin
            bar_length  <= bar_next;
            level_class <= class_next;
            level_db    <= db;
            state       <= dpm_pkg::ST_IDLE;
          end
        end
        default: state <= dpm_pkg::ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_emit_only: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == dpm_pkg::ST_EMIT)
    else $error("result raised outside emit");

  a_db_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (level_db <= 16'sd0) && (level_db >= -16'sd30720))
    else $error("level out of range");

  a_bar_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bar_length != '0)
    else $error("empty bar");

  a_plain_sample: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !buffer_end |=> state == dpm_pkg::ST_IDLE)
    else $error("plain sample left idle");

  a_norm_done: assert property (@(posedge clk) disable iff (rst)
    state == dpm_pkg::ST_INTERP |-> norm_val[MAG_BITS-1])
    else $error("interpolation on unnormalised peak");
`endif

endmodule
